FILE: sv/assert_macros.svh
// Assertion macros shared by the digitizer record parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define DRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define DRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/drp_pkg.sv
// Shared types and constants of the digitizer record parser
`timescale 1ns / 1ps
`default_nettype none

package drp_pkg;

	// Line buffer and field limits
	localparam int unsigned LINE_MAX         = 100;
	localparam int unsigned MAX_FIELD_DIGITS = 9;
	localparam logic [29:0] ACC_MAX          = 30'h3FFF_FFFF;

	// Record terminators
	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [7:0] CHAR_CR = 8'd13;

	// Configuration register indexes
	localparam logic [2:0] REG_MIN_RECORD_LEN = 3'd0;
	localparam logic [2:0] REG_X_START        = 3'd1;
	localparam logic [2:0] REG_X_DIGITS       = 3'd2;
	localparam logic [2:0] REG_Y_START        = 3'd3;
	localparam logic [2:0] REG_Y_DIGITS       = 3'd4;
	localparam logic [2:0] REG_FLAG_COLUMN    = 3'd5;
	localparam logic [2:0] REG_BUTTON_CODES   = 3'd6;
	localparam logic [2:0] REG_EMIT_ON_CHANGE = 3'd7;

	// Field parse phase codes
	localparam logic [1:0] PH_LEAD   = 2'd0;
	localparam logic [1:0] PH_DIGITS = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	typedef struct packed {
		logic [6:0]  min_record_len;
		logic [6:0]  x_start;
		logic [3:0]  x_digits;
		logic [6:0]  y_start;
		logic [3:0]  y_digits;
		logic [6:0]  flag_column;
		logic [31:0] button_codes;
		logic        emit_on_change_only;
	} drp_cfg_t;

	typedef struct packed {
		logic signed [30:0] x_value;
		logic signed [30:0] y_value;
		logic [1:0]         button_index;
		logic               button_valid;
	} drp_result_t;

endpackage

`default_nettype wire

FILE: sv/drp_field.sv
// Incremental decimal field parser for one coordinate field
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module drp_field import drp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               feed,
	input  wire logic               clear,
	input  wire logic [7:0]         ch,
	input  wire logic [6:0]         pos,
	input  wire logic [6:0]         start,
	input  wire logic [3:0]         len,
	output logic signed [30:0]      value
);

	logic [29:0] acc_q, acc_d;
	logic [1:0]  phase_q, phase_d;
	logic        neg_q, neg_d;
	logic [3:0]  len_eff;
	logic [6:0]  offset;
	logic        in_window;
	logic        is_digit;
	logic        is_space;
	logic [33:0] acc_next;
	logic [30:0] mag;

	// Clamp the field length and check the column window
	assign len_eff   = (len > 4'(MAX_FIELD_DIGITS)) ? 4'(MAX_FIELD_DIGITS) : len;
	assign offset    = pos - start;
	assign in_window = (start != 7'd0) && (pos >= start) && (offset < {3'b0, len_eff})
		&& (phase_q != PH_DONE);

	assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
	assign is_space = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0B) || (ch == 8'h0C);

	// Multiply by ten and add the digit
	assign acc_next = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + {30'b0, ch[3:0]};

	// Next field state
	always_comb begin
		acc_d   = acc_q;
		phase_d = phase_q;
		neg_d   = neg_q;
		if (clear) begin
			acc_d   = '0;
			phase_d = PH_LEAD;
			neg_d   = 1'b0;
		end else if (feed && in_window) begin
			if (phase_q == PH_LEAD && !is_digit) begin
				if (ch == 8'h2B) begin
					phase_d = PH_DIGITS;
					neg_d   = 1'b0;
				end else if (ch == 8'h2D) begin
					phase_d = PH_DIGITS;
					neg_d   = 1'b1;
				end else if (!is_space) begin
					phase_d = PH_DONE;
					neg_d   = 1'b0;
				end
			end else if (!is_digit) begin
				phase_d = PH_DONE;
			end else begin
				acc_d   = (acc_next > {4'b0, ACC_MAX}) ? ACC_MAX : acc_next[29:0];
				phase_d = PH_DIGITS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			phase_q <= PH_LEAD;
			neg_q   <= 1'b0;
		end else begin
			acc_q   <= acc_d;
			phase_q <= phase_d;
			neg_q   <= neg_d;
		end
	end

	// Apply the sign
	assign mag   = {1'b0, acc_q};
	assign value = neg_q ? -$signed(mag) : $signed(mag);

	`DRP_ASSERT_NEXT(a_done_holds, phase_q == PH_DONE && !clear, $stable(acc_q) && phase_q == PH_DONE, "finished field changed without a clear")
	`DRP_ASSERT_NEXT(a_clear_resets, clear, acc_q == 30'd0 && phase_q == PH_LEAD && !neg_q, "field not cleared")

endmodule

`default_nettype wire

FILE: sv/drp_outq.sv
// Two-entry result queue between the record logic and the output channel
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module drp_outq import drp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire drp_result_t push_data,
	input  wire logic        pending,
	output logic             no_room,
	output logic             out_valid,
	input  wire logic        out_stall,
	output drp_result_t      out_data
);

	drp_result_t entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign out_data  = entry_q[rd_ptr_q];

	// Hold off new bytes when the item in flight might not find a slot
	assign no_room = (count_q == 2'd2 && (!pop || pending))
		|| (count_q == 2'd1 && pending && !pop);

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`DRP_ASSERT(a_no_overflow, !(push && count_q == 2'd2 && !pop), "result pushed into a full queue")
	`DRP_ASSERT(a_count_range, count_q != 2'd3, "queue count out of range")

endmodule

`default_nettype wire

FILE: sv/drp_rec.sv
// Record framing, flag capture, button match and change detection
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module drp_rec import drp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire drp_cfg_t    cfg,
	input  wire logic        valid_s1,
	input  wire logic [7:0]  byte_s1,
	output logic             res_push,
	output drp_result_t      res
);

	logic [6:0]         line_position_q;
	logic               first_record_done_q;
	logic [7:0]         captured_flag_q;
	logic signed [30:0] last_x_q;
	logic signed [30:0] last_y_q;
	logic [2:0]         last_button_q;

	logic               is_term;
	logic               overflow;
	logic               feed;
	logic               clear;
	logic [6:0]         pos_next;
	logic signed [30:0] x_field;
	logic signed [30:0] y_field;
	logic               record_end;
	logic               full_record;
	logic [2:0]         match_button;
	logic signed [30:0] new_x;
	logic signed [30:0] new_y;
	logic [2:0]         new_button;
	logic               changed;

	// Classify the byte in flight
	assign is_term  = (byte_s1 == CHAR_LF) || (byte_s1 == CHAR_CR);
	assign overflow = (line_position_q >= 7'(LINE_MAX));
	assign feed     = valid_s1 && !is_term && !overflow;
	assign clear    = valid_s1 && (is_term || overflow);
	assign pos_next = line_position_q + 7'd1;

	drp_field u_x_field (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.clear  (clear),
		.ch     (byte_s1),
		.pos    (pos_next),
		.start  (cfg.x_start),
		.len    (cfg.x_digits),
		.value  (x_field)
	);

	drp_field u_y_field (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.clear  (clear),
		.ch     (byte_s1),
		.pos    (pos_next),
		.start  (cfg.y_start),
		.len    (cfg.y_digits),
		.value  (y_field)
	);

	// Match the flag against the four codes, lowest index wins
	always_comb begin
		match_button = 3'b000;
		for (int k = 3; k >= 0; k--) begin
			if (cfg.button_codes[8*k +: 8] == captured_flag_q) begin
				match_button = {1'b1, 2'(k)};
			end
		end
	end

	// Build the new values and detect a change
	assign record_end  = valid_s1 && is_term && first_record_done_q && (line_position_q != 7'd0);
	assign full_record = (line_position_q >= cfg.min_record_len);
	assign new_x       = full_record ? x_field : last_x_q;
	assign new_y       = full_record ? y_field : last_y_q;
	assign new_button  = full_record ? match_button : last_button_q;
	assign changed     = (new_x != last_x_q) || (new_y != last_y_q)
		|| (new_button != last_button_q);

	assign res_push          = record_end && (!cfg.emit_on_change_only || changed);
	assign res.x_value       = new_x;
	assign res.y_value       = new_y;
	assign res.button_index  = new_button[1:0];
	assign res.button_valid  = new_button[2];

	// Track line position, flag and last values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_position_q     <= '0;
			first_record_done_q <= 1'b0;
			captured_flag_q     <= '0;
			last_x_q            <= '0;
			last_y_q            <= '0;
			last_button_q       <= '0;
		end else begin
			if (clear) begin
				line_position_q <= '0;
				captured_flag_q <= '0;
			end else if (feed) begin
				line_position_q <= pos_next;
				if (cfg.flag_column != 7'd0 && pos_next == cfg.flag_column) begin
					captured_flag_q <= byte_s1;
				end
			end
			if (valid_s1 && is_term) begin
				first_record_done_q <= 1'b1;
			end
			if (record_end) begin
				last_x_q      <= new_x;
				last_y_q      <= new_y;
				last_button_q <= new_button;
			end
		end
	end

	`DRP_ASSERT(a_pos_range, line_position_q <= 7'(LINE_MAX), "line position beyond buffer")
	`DRP_ASSERT_NEXT(a_term_restarts, valid_s1 && is_term, line_position_q == 7'd0 && first_record_done_q, "terminator did not restart the record")

endmodule

`default_nettype wire

FILE: sv/digitizer_record_parser_top.sv
// Top level of the digitizer record parser: config registers, input stage, result queue
// Usage:
//   Input channel in_valid / in_stall carries one received character rx_byte per
//   transfer. CR or LF ends a record; the first record after reset is ignored and
//   empty records are skipped. Result channel out_valid / out_stall carries x_value,
//   y_value, button_index and button_valid, at most one per terminating character.
//   Throughput: one character per cycle while in_stall is low. Each character
//   is registered, then one pass of compare and multiply-by-ten logic updates
//   the field state and, on a terminator, writes a result into a two-entry queue.
//   A terminator is registered in the input stage, then its result is written
//   into the queue, which raises out_valid.
//   When the receiver stalls, the queue absorbs results and in_stall rises only
//   when the queue could not take the character in flight.
//   Configuration registers are written through write_enable / write_index /
//   write_data; the user writes them only while the block is idle (not enforced).
//   Reset clears the line position, the parse state, the last values and the
//   queue, and loads the default register values.
`timescale 1ns / 1ps
`default_nettype none

module digitizer_record_parser_top import drp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               write_enable,
	input  wire logic [2:0]         write_index,
	input  wire logic [31:0]        write_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [30:0]      x_value,
	output logic signed [30:0]      y_value,
	output logic [1:0]              button_index,
	output logic                    button_valid
);

	drp_cfg_t    cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        res_push;
	drp_result_t res;
	drp_result_t out_data;
	logic        no_room;
	logic        in_xfer;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_record_len      <= 7'd13;
			cfg_q.x_start             <= 7'd1;
			cfg_q.x_digits            <= 4'd5;
			cfg_q.y_start             <= 7'd7;
			cfg_q.y_digits            <= 4'd5;
			cfg_q.flag_column         <= 7'd12;
			cfg_q.button_codes        <= 32'h3834_3231;
			cfg_q.emit_on_change_only <= 1'b1;
		end else if (write_enable) begin
			case (write_index)
				REG_MIN_RECORD_LEN: cfg_q.min_record_len      <= write_data[6:0];
				REG_X_START:        cfg_q.x_start             <= write_data[6:0];
				REG_X_DIGITS:       cfg_q.x_digits            <= write_data[3:0];
				REG_Y_START:        cfg_q.y_start             <= write_data[6:0];
				REG_Y_DIGITS:       cfg_q.y_digits            <= write_data[3:0];
				REG_FLAG_COLUMN:    cfg_q.flag_column         <= write_data[6:0];
				REG_BUTTON_CODES:   cfg_q.button_codes        <= write_data;
				REG_EMIT_ON_CHANGE: cfg_q.emit_on_change_only <= write_data[0];
				default: ;
			endcase
		end
	end

	// Register each transferred character
	assign in_stall = no_room;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= rx_byte;
		end
	end

	drp_rec u_rec (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.res_push (res_push),
		.res      (res)
	);

	drp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.pending   (valid_s1),
		.no_room   (no_room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign x_value      = out_data.x_value;
	assign y_value      = out_data.y_value;
	assign button_index = out_data.button_index;
	assign button_valid = out_data.button_valid;

endmodule

`default_nettype wire

FILE: dv/drp_result_checker.sv
// Checker that predicts each parsed digitizer record and compares it with the block output
`timescale 1ns / 1ps

module drp_result_checker import drp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               write_enable,
	input  logic [2:0]         write_index,
	input  logic [31:0]        write_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [30:0] x_value,
	input  logic signed [30:0] y_value,
	input  logic [1:0]         button_index,
	input  logic               button_valid,
	output int                 results_owed,
	output int                 fail_count
);

	// Sign flag of a field, kept above the two phase bits
	localparam int NEG_BIT = 2;

	drp_cfg_t           regs;
	logic [6:0]         col_pos;
	logic               seen_first_record;
	logic [29:0]        x_acc;
	logic [29:0]        y_acc;
	logic [2:0]         x_phase;
	logic [2:0]         y_phase;
	logic [7:0]         flag_char;
	logic signed [30:0] prev_x;
	logic signed [30:0] prev_y;
	logic [2:0]         prev_button;	// bit 2 matched, bits 1:0 code index
	drp_result_t        owed_reports [$];
	drp_result_t        oldest;
	int                 mismatches;

	// Advance one number field by one character at 1-based column col
	function automatic void scan_field(input logic [7:0] c, input int col,
			input logic [6:0] start, input logic [3:0] width,
			inout logic [29:0] acc, inout logic [2:0] phase);
		int          span;
		logic        is_digit;
		logic [63:0] grown;
		span = (int'(width) > int'(MAX_FIELD_DIGITS)) ? int'(MAX_FIELD_DIGITS) : int'(width);
		is_digit = (c >= 8'h30) && (c <= 8'h39);
		if (start == 7'd0 || col < int'(start) || col - int'(start) >= span ||
				phase[1:0] == PH_DONE)
			return;
		if (phase[1:0] == PH_LEAD && !is_digit) begin
			// skip white space, take a sign, anything else ends the field
			if (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C)
				return;
			if (c == 8'h2B)
				phase = {1'b0, PH_DIGITS};
			else if (c == 8'h2D)
				phase = {1'b1, PH_DIGITS};
			else
				phase = {1'b0, PH_DONE};
			return;
		end
		if (!is_digit) begin
			phase = {phase[NEG_BIT], PH_DONE};
			return;
		end
		// accumulate and saturate the magnitude
		grown = 64'(acc) * 64'd10 + 64'(c - 8'h30);
		acc = (grown > 64'(ACC_MAX)) ? ACC_MAX : grown[29:0];
		phase = {phase[NEG_BIT], PH_DIGITS};
	endfunction

	function automatic logic signed [30:0] signed_field(input logic [29:0] acc,
			input logic [2:0] phase);
		logic signed [30:0] mag;
		mag = {1'b0, acc};
		return phase[NEG_BIT] ? -mag : mag;
	endfunction

	task automatic clear_line();
		col_pos = 7'd0;
		x_acc = 30'd0;
		y_acc = 30'd0;
		x_phase = {1'b0, PH_LEAD};
		y_phase = {1'b0, PH_LEAD};
		flag_char = 8'h00;
	endtask

	// Update the record state for one transferred character
	task automatic parse_rx_char(input logic [7:0] c);
		logic signed [30:0] nx;
		logic signed [30:0] ny;
		logic [2:0]         nb;
		logic               changed;
		drp_result_t        r;
		int                 k;
		int                 col;
		if (c == CHAR_LF || c == CHAR_CR) begin
			if (seen_first_record && col_pos != 7'd0) begin
				nx = prev_x;
				ny = prev_y;
				nb = prev_button;
				if (col_pos >= regs.min_record_len) begin
					nx = signed_field(x_acc, x_phase);
					ny = signed_field(y_acc, y_phase);
					nb = 3'b000;
					// lowest matching code wins
					for (k = 3; k >= 0; k--)
						if (regs.button_codes[8*k +: 8] == flag_char)
							nb = {1'b1, 2'(k)};
				end
				changed = (nx != prev_x) || (ny != prev_y) || (nb != prev_button);
				prev_x = nx;
				prev_y = ny;
				prev_button = nb;
				if (!regs.emit_on_change_only || changed) begin
					r.x_value = nx;
					r.y_value = ny;
					r.button_index = nb[2] ? nb[1:0] : 2'd0;
					r.button_valid = nb[2];
					owed_reports.push_back(r);
				end
			end
			seen_first_record = 1'b1;
			clear_line();
		end else if (int'(col_pos) >= int'(LINE_MAX)) begin
			// drop the character and restart the line
			clear_line();
		end else begin
			col = int'(col_pos) + 1;
			scan_field(c, col, regs.x_start, regs.x_digits, x_acc, x_phase);
			scan_field(c, col, regs.y_start, regs.y_digits, y_acc, y_phase);
			if (regs.flag_column != 7'd0 && col == int'(regs.flag_column))
				flag_char = c;
			col_pos = 7'(col);
		end
	endtask

	// Compare one result transfer with the oldest owed report
	task automatic check_report();
		if (owed_reports.size() == 0) begin
			$error("result transfer with no report owed: x %0d y %0d", x_value, y_value);
			mismatches++;
			return;
		end
		oldest = owed_reports.pop_front();
		if (x_value !== oldest.x_value) begin
			$error("x_value expected %0d got %0d", oldest.x_value, x_value);
			mismatches++;
		end
		if (y_value !== oldest.y_value) begin
			$error("y_value expected %0d got %0d", oldest.y_value, y_value);
			mismatches++;
		end
		if (button_index !== oldest.button_index) begin
			$error("button_index expected %0d got %0d", oldest.button_index, button_index);
			mismatches++;
		end
		if (button_valid !== oldest.button_valid) begin
			$error("button_valid expected %0d got %0d", oldest.button_valid, button_valid);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.min_record_len = 7'd13;
			regs.x_start = 7'd1;
			regs.x_digits = 4'd5;
			regs.y_start = 7'd7;
			regs.y_digits = 4'd5;
			regs.flag_column = 7'd12;
			regs.button_codes = 32'h3834_3231;
			regs.emit_on_change_only = 1'b1;
			seen_first_record = 1'b0;
			prev_x = 31'sd0;
			prev_y = 31'sd0;
			prev_button = 3'b000;
			clear_line();
			owed_reports.delete();
			mismatches = 0;
			results_owed <= 0;
			fail_count <= 0;
		end else begin
			// track register writes
			if (write_enable) begin
				case (write_index)
					REG_MIN_RECORD_LEN: regs.min_record_len = write_data[6:0];
					REG_X_START:        regs.x_start = write_data[6:0];
					REG_X_DIGITS:       regs.x_digits = write_data[3:0];
					REG_Y_START:        regs.y_start = write_data[6:0];
					REG_Y_DIGITS:       regs.y_digits = write_data[3:0];
					REG_FLAG_COLUMN:    regs.flag_column = write_data[6:0];
					REG_BUTTON_CODES:   regs.button_codes = write_data;
					REG_EMIT_ON_CHANGE: regs.emit_on_change_only = write_data[0];
					default: ;
				endcase
			end
			// check before predicting: a result never belongs to this edge's input
			if (out_valid && !out_stall)
				check_report();
			if (in_valid && !in_stall)
				parse_rx_char(rx_byte);
			results_owed <= owed_reports.size();
			fail_count <= mismatches;
		end
	end

endmodule

FILE: dv/digitizer_record_parser_top_tb.sv
// Testbench top: drives digitizer character streams and register settings, gives the verdict
`timescale 1ns / 1ps

module digitizer_record_parser_top_tb import drp_pkg::*;;

	localparam int QUIET_LIMIT  = 2000;
	localparam int LONG_HOLD    = 300;
	localparam int DIRECTED_LEN = 26;

	// Short hand-made records: empty, signs, white space, short, NUL, no match
	localparam logic [8*DIRECTED_LEN-1:0] DIRECTED_LINE = {
		8'h0D,
		8'h2D, 8'h39, 8'h2B, 8'h37, 8'h32, 8'h0A,
		8'h09, 8'h35, 8'h20, 8'h33, 8'h0D,
		8'h31, 8'h0A,
		8'h00, 8'hFF, 8'h2E, 8'h38, 8'h38, 8'h0D,
		8'h37, 8'h37, 8'h5A, 8'h34, 8'h78, 8'h0A
	};

	typedef enum int {REC_FORMED, REC_SHORT, REC_EMPTY, REC_NOISE, REC_OVERFLOW} record_kind_e;

	logic               clk;
	logic               arst_n;
	logic               write_enable;
	logic [2:0]         write_index;
	logic [31:0]        write_data;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_stall;
	logic signed [30:0] x_value;
	logic signed [30:0] y_value;
	logic [1:0]         button_index;
	logic               button_valid;
	int                 results_owed;
	int                 fail_count;

	drp_cfg_t   cur_cfg;
	drp_cfg_t   next_cfg;
	logic [7:0] line_buf [$];
	int         chars_sent = 0;
	int         send_gap_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_requests = 0;
	int         quiet_cycles = 0;

	digitizer_record_parser_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_data   (write_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.x_value      (x_value),
		.y_value      (y_value),
		.button_index (button_index),
		.button_valid (button_valid)
	);

	drp_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_data   (write_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.x_value      (x_value),
		.y_value      (y_value),
		.button_index (button_index),
		.button_valid (button_valid),
		.results_owed (results_owed),
		.fail_count   (fail_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// End the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: random stall bursts, plus long hold-offs on request
	initial begin : receiver
		int held;
		out_stall = 1'b0;
		held = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (held < hold_requests) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
				held++;
			end else if ($urandom_range(0, 99) < recv_stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic int idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 8;
			default: return 25;
		endcase
	endfunction

	// Any byte except a record terminator
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == CHAR_LF || c == CHAR_CR)
			c = 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 5))
			0: return 8'h09;
			1: return 8'h0B;
			2: return 8'h0C;
			default: return 8'h20;
		endcase
	endfunction

	function automatic int field_end(input logic [6:0] start, input logic [3:0] width);
		return (start == 7'd0) ? 0 : int'(start) + int'(width) - 1;
	endfunction

	function automatic drp_cfg_t random_settings();
		drp_cfg_t s;
		int       k;
		s.min_record_len = 7'($urandom_range(0, 24));
		s.x_start = 7'($urandom_range(1, 12));
		s.x_digits = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(10, 15)
			: $urandom_range(1, 9));
		s.y_start = 7'($urandom_range(1, 24));
		s.y_digits = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(10, 15)
			: $urandom_range(1, 9));
		s.flag_column = 7'($urandom_range(1, 30));
		for (k = 0; k < 4; k++)
			s.button_codes[8*k +: 8] = 8'($urandom_range(8'h21, 8'h7A));
		s.emit_on_change_only = 1'($urandom_range(0, 1));
		return s;
	endfunction

	// Offer one character, with an optional gap before it
	task automatic put_char(input logic [7:0] c);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		chars_sent++;
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			put_char(line_buf[i]);
	endtask

	// Stop offering and wait until every owed result has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_owed != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		write_enable <= 1'b1;
		write_index <= idx;
		write_data <= value;
		@(negedge clk);
	endtask

	// Write every register once the block has gone idle
	task automatic load_settings(input drp_cfg_t s);
		drain();
		repeat (4) @(negedge clk);
		write_reg(REG_MIN_RECORD_LEN, 32'(s.min_record_len));
		write_reg(REG_X_START, 32'(s.x_start));
		write_reg(REG_X_DIGITS, 32'(s.x_digits));
		write_reg(REG_Y_START, 32'(s.y_start));
		write_reg(REG_Y_DIGITS, 32'(s.y_digits));
		write_reg(REG_FLAG_COLUMN, 32'(s.flag_column));
		write_reg(REG_BUTTON_CODES, s.button_codes);
		write_reg(REG_EMIT_ON_CHANGE, 32'(s.emit_on_change_only));
		write_enable <= 1'b0;
		cur_cfg = s;
	endtask

	// Write a number pattern into a field: junk, or blanks, sign, digits, maybe a fraction
	task automatic place_number(input int start, input int width, input int len);
		logic [7:0] pat [$];
		int         i;
		if (start == 0)
			return;
		if ($urandom_range(0, 9) == 0) begin
			// junk field
			repeat (width) pat.push_back(plain_char());
		end else begin
			repeat ($urandom_range(0, 2)) pat.push_back(blank_char());
			case ($urandom_range(0, 3))
				0: pat.push_back(8'h2D);
				1: pat.push_back(8'h2B);
				default: ;
			endcase
			repeat ($urandom_range(1, 9)) pat.push_back(8'($urandom_range(8'h30, 8'h39)));
			if ($urandom_range(0, 2) == 0) begin
				pat.push_back(8'h2E);
				repeat (2) pat.push_back(8'($urandom_range(8'h30, 8'h39)));
			end
		end
		for (i = 0; i < pat.size() && i < width && start + i <= len; i++)
			line_buf[start + i - 1] = pat[i];
	endtask

	// Build one record, terminator included, for the current layout
	task automatic build_record(input record_kind_e kind);
		int         len;
		int         span;
		int         upper;
		logic [7:0] code;
		line_buf.delete();
		case (kind)
			REC_EMPTY: ;
			REC_NOISE: begin
				repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
			end
			REC_OVERFLOW: begin
				repeat ($urandom_range(101, 112)) line_buf.push_back(plain_char());
			end
			default: begin
				span = field_end(cur_cfg.x_start, cur_cfg.x_digits);
				if (field_end(cur_cfg.y_start, cur_cfg.y_digits) > span)
					span = field_end(cur_cfg.y_start, cur_cfg.y_digits);
				if (int'(cur_cfg.flag_column) > span)
					span = int'(cur_cfg.flag_column);
				if (kind == REC_FORMED) begin
					len = ((span > int'(cur_cfg.min_record_len)) ? span
						: int'(cur_cfg.min_record_len)) + $urandom_range(0, 3);
				end else begin
					upper = int'(cur_cfg.min_record_len) - 1;
					if (upper > 12)
						upper = 12;
					if (upper < 1)
						upper = 1;
					len = $urandom_range(1, upper);
				end
				if (len > int'(LINE_MAX))
					len = int'(LINE_MAX);
				if (len < 1)
					len = 1;
				repeat (len) line_buf.push_back(($urandom_range(0, 3) == 0) ? plain_char() : 8'h20);
				place_number(int'(cur_cfg.x_start), int'(cur_cfg.x_digits), len);
				place_number(int'(cur_cfg.y_start), int'(cur_cfg.y_digits), len);
				if (cur_cfg.flag_column != 7'd0 && int'(cur_cfg.flag_column) <= len) begin
					code = ($urandom_range(0, 99) < 85)
						? cur_cfg.button_codes[8*$urandom_range(0, 3) +: 8] : plain_char();
					if (code == CHAR_LF || code == CHAR_CR)
						code = 8'h3F;
					line_buf[cur_cfg.flag_column - 1] = code;
				end
			end
		endcase
		line_buf.push_back(($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF);
	endtask

	// Mostly well-formed records, some short, empty, noisy and overlong ones
	task automatic run_records(input int budget);
		int           first_char;
		int           pick;
		record_kind_e kind;
		first_char = chars_sent;
		while (chars_sent - first_char < budget) begin
			// pause the sender now and then, but never in a stretch without idling
			if (send_gap_pct != 0 && $urandom_range(0, 99) < 4)
				drain();
			pick = $urandom_range(0, 99);
			if (pick < 66)
				kind = REC_FORMED;
			else if (pick < 78)
				kind = REC_SHORT;
			else if (pick < 84)
				kind = REC_EMPTY;
			else if (pick < 97)
				kind = REC_NOISE;
			else
				kind = REC_OVERFLOW;
			build_record(kind);
			send_line();
		end
	endtask

	initial begin : stimulus
		int i;
		int ph;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		write_enable = 1'b0;
		write_index = REG_MIN_RECORD_LEN;
		write_data = 32'h0;
		cur_cfg.min_record_len = 7'd13;
		cur_cfg.x_start = 7'd1;
		cur_cfg.x_digits = 4'd5;
		cur_cfg.y_start = 7'd7;
		cur_cfg.y_digits = 4'd5;
		cur_cfg.flag_column = 7'd12;
		cur_cfg.button_codes = 32'h3834_3231;
		cur_cfg.emit_on_change_only = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset layout; the first record is swallowed
		send_gap_pct = 20;
		recv_stall_pct = 20;
		run_records(120);
		build_record(REC_OVERFLOW);
		send_line();

		// compact layout for the hand-made records; a zero code catches an absent flag
		next_cfg.min_record_len = 7'd3;
		next_cfg.x_start = 7'd1;
		next_cfg.x_digits = 4'd2;
		next_cfg.y_start = 7'd3;
		next_cfg.y_digits = 4'd2;
		next_cfg.flag_column = 7'd5;
		next_cfg.button_codes = 32'h0038_3432;
		next_cfg.emit_on_change_only = 1'b0;
		load_settings(next_cfg);
		for (i = DIRECTED_LEN - 1; i >= 0; i--)
			put_char(DIRECTED_LINE[8*i +: 8]);

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					// zero columns, empty X, overlong Y, zero codes
					next_cfg.min_record_len = 7'd0;
					next_cfg.x_start = 7'd0;
					next_cfg.x_digits = 4'd0;
					next_cfg.y_start = 7'd1;
					next_cfg.y_digits = 4'd15;
					next_cfg.flag_column = 7'd0;
					next_cfg.button_codes = 32'h0;
					next_cfg.emit_on_change_only = 1'b1;
				end
				3: begin
					// top values: every record is short, fields at or past the line end
					next_cfg.min_record_len = 7'd127;
					next_cfg.x_start = 7'd127;
					next_cfg.x_digits = 4'd15;
					next_cfg.y_start = 7'd100;
					next_cfg.y_digits = 4'd9;
					next_cfg.flag_column = 7'd127;
					next_cfg.button_codes = 32'hFFFF_FFFF;
					next_cfg.emit_on_change_only = 1'b0;
				end
				5: begin
					// every record reports, so the result queue fills during the hold
					next_cfg.min_record_len = 7'd0;
					next_cfg.x_start = 7'd1;
					next_cfg.x_digits = 4'd2;
					next_cfg.y_start = 7'd3;
					next_cfg.y_digits = 4'd2;
					next_cfg.flag_column = 7'd5;
					next_cfg.button_codes = $urandom();
					next_cfg.emit_on_change_only = 1'b0;
				end
				default: next_cfg = random_settings();
			endcase
			load_settings(next_cfg);
			if (ph == 7) begin
				// no idling in the last stretch
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end else begin
				send_gap_pct = idle_pct();
				recv_stall_pct = idle_pct();
			end
			if (ph == 5) begin
				send_gap_pct = 0;
				hold_requests++;
				repeat (24) begin
					build_record(REC_FORMED);
					send_line();
				end
			end else begin
				run_records(120);
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && results_owed == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/drp_pkg.sv
sv/drp_field.sv
sv/drp_outq.sv
sv/drp_rec.sv
sv/digitizer_record_parser_top.sv
dv/drp_result_checker.sv
dv/digitizer_record_parser_top_tb.sv
